// ===== rtl/icm_pkg.sv =====
// Shared widths, defaults and result codes of the incremental cluster merge block.
package icm_pkg;

  // Fixed field widths of the stream beats.
  localparam int NODE_W      = 10;
  localparam int LABEL_W     = 9;
  localparam int COUNT_W     = 11;
  localparam int LINKS_W     = 16;
  localparam int CASE_W      = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_USED_W  = LABEL_W + 3 * COUNT_W + LINKS_W;
  localparam int OUT_TDATA_W = 64;

  // Default sizes of the node and label stores.
  localparam int NODES_DEF  = 1024;
  localparam int LABELS_DEF = 512;

  // What a link did to the clusters.
  typedef enum logic [CASE_W-1:0] {
    CASE_NEW    = 2'd0,
    CASE_JOIN   = 2'd1,
    CASE_INSIDE = 2'd2,
    CASE_MERGE  = 2'd3
  } merge_case_t;

endpackage

// ===== rtl/incremental_cluster_merge.sv =====
// Top level of the incremental cluster merge block (union by size over a label memory).
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+-------------------------------------------
//  in_     | in  | in_tvalid / in_tready    | in_tdata: node_a, node_b
//  out_    | out | out_tvalid / out_tready  | out_tuser: merge_case; out_tdata: the rest
//
// A plain item runs from its beat to the result register through the reduction of the node
// numbers, two node memory reads, two size memory reads and the decision cycle, and the next
// beat is taken only once the block is back in idle. Each subtraction of NODES from a large
// node number adds a step, a new cluster adds one for the second node write, and a merge
// then sweeps the node memory, one entry a cycle. After reset a clearing pass keeps
// in_tready low; a waiting result stalls only the decision cycle of the next item.
module incremental_cluster_merge #(
  parameter int NODES  = icm_pkg::NODES_DEF,
  parameter int LABELS = icm_pkg::LABELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata from bit 0: node_a[9:0], node_b[19:10], zero fill.
  input  logic [icm_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata from bit 0: cluster_label[8:0], cluster_nodes[19:9], largest_cluster[30:20],
  // connected_nodes[41:31], links_placed[57:42], zero fill.
  output logic [icm_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser from bit 0: merge_case[1:0].
  output logic [icm_pkg::CASE_W-1:0]      out_tuser
);

  localparam int IW   = icm_pkg::NODE_W;
  localparam int LBW  = icm_pkg::LABEL_W;
  localparam int CNW  = icm_pkg::COUNT_W;
  localparam int LKW  = icm_pkg::LINKS_W;
  localparam int PADW = icm_pkg::OUT_TDATA_W - icm_pkg::OUT_USED_W;
  // Node address, label, entry, size, free label and sweep counter widths.
  localparam int NW   = $clog2(NODES);
  localparam int LW   = $clog2(LABELS);
  localparam int EW   = LW + 1;
  localparam int SW   = $clog2(NODES + 1);
  localparam int FW   = $clog2(LABELS + 1);
  localparam int CW   = $clog2(NODES + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RED, S_RDA, S_RDB, S_RSA, S_RSB, S_EXEC, S_WB, S_SCAN
  } state_t;

  // Node memory entry: {labelled, label}. Size memory holds node counts per label.
  logic [EW-1:0] node_mem [NODES];
  logic [SW-1:0] size_mem [LABELS];

  state_t              state_r;
  logic [CW-1:0]       cnt_r;
  logic [IW-1:0]       a_r, b_r;
  logic [EW-1:0]       ent_a_r, ent_b_r, n_rdata_r;
  logic [SW-1:0]       sa_r, s_rdata_r;
  logic [LW-1:0]       lab_r, lose_r;
  logic [FW-1:0]       free_r;
  logic [SW-1:0]       largest_r, conn_r;
  logic [LKW-1:0]      placed_r;
  logic                out_tvalid_r;
  logic [icm_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [icm_pkg::CASE_W-1:0]      out_tuser_r;

  // Memory port controls.
  logic          n_re, n_we, s_re, s_we;
  logic [NW-1:0] n_raddr, n_waddr;
  logic [EW-1:0] n_wdata;
  logic [LW-1:0] s_raddr, s_waddr;
  logic [SW-1:0] s_wdata;

  // Decision of the current item.
  logic                 la, lb, same_node, free_left, a_wins, out_free;
  logic [LW-1:0]        ia, ib, ex_lab, lose;
  logic [SW-1:0]        sb, s_join, ex_sz;
  logic                 ex_note, ex_open;
  logic [1:0]           ex_add;
  icm_pkg::merge_case_t ex_case;
  logic [SW-1:0]        largest_nxt, conn_nxt;
  logic [LKW-1:0]       placed_nxt;
  logic [icm_pkg::OUT_TDATA_W-1:0] out_tdata_nxt;
  logic                 out_tvalid_nxt;
  logic                 scan_hit;

  assign la        = ent_a_r[LW];
  assign lb        = ent_b_r[LW];
  assign ia        = ent_a_r[LW-1:0];
  assign ib        = ent_b_r[LW-1:0];
  assign sb        = s_rdata_r;
  assign same_node = (a_r == b_r);
  assign free_left = (free_r < FW'(LABELS));
  assign a_wins    = (sa_r > sb);
  assign lose      = a_wins ? ib : ia;
  assign s_join    = la ? sa_r : sb;
  assign out_free  = !out_tvalid_r || out_tready;

  // Classify the link and work out the reported label and size.
  always_comb begin
    ex_case = icm_pkg::CASE_INSIDE;
    ex_lab  = '0;
    ex_sz   = '0;
    ex_note = 1'b0;
    ex_open = 1'b0;
    ex_add  = 2'd0;
    if (!la && !lb) begin
      if (same_node) begin
        ex_case = icm_pkg::CASE_INSIDE;
        ex_sz   = SW'(1);
      end else if (!free_left) begin
        ex_case = icm_pkg::CASE_NEW;
      end else begin
        ex_case = icm_pkg::CASE_NEW;
        ex_lab  = LW'(free_r);
        ex_sz   = SW'(2);
        ex_note = 1'b1;
        ex_open = 1'b1;
        ex_add  = 2'd2;
      end
    end else if (la != lb) begin
      ex_case = icm_pkg::CASE_JOIN;
      ex_lab  = la ? ia : ib;
      ex_sz   = s_join + SW'(1);
      ex_note = 1'b1;
      ex_add  = 2'd1;
    end else if (ia == ib) begin
      ex_case = icm_pkg::CASE_INSIDE;
      ex_lab  = ib;
      ex_sz   = sb;
    end else begin
      ex_case = icm_pkg::CASE_MERGE;
      ex_lab  = a_wins ? ia : ib;
      ex_sz   = sa_r + sb;
      ex_note = 1'b1;
    end
  end

  assign largest_nxt = (ex_note && (ex_sz > largest_r)) ? ex_sz : largest_r;
  assign conn_nxt    = conn_r + SW'(ex_add);
  assign placed_nxt  = (placed_r == '1) ? placed_r : placed_r + LKW'(1);
  assign out_tdata_nxt = {{PADW{1'b0}}, placed_nxt, CNW'(conn_nxt), CNW'(largest_nxt),
                          CNW'(ex_sz), LBW'(ex_lab)};

  // The result register fills on a decision and empties when its beat is taken.
  assign out_tvalid_nxt = ((state_r == S_EXEC) && out_free) || (out_tvalid_r && !out_tready);

  // During a merge sweep, the entry read in the previous cycle is rewritten when it
  // carries the losing label.
  assign scan_hit = (cnt_r != '0) && n_rdata_r[LW] && (n_rdata_r[LW-1:0] == lose_r);

  always_comb begin
    n_re    = 1'b0;
    n_raddr = '0;
    n_we    = 1'b0;
    n_waddr = '0;
    n_wdata = '0;
    s_re    = 1'b0;
    s_raddr = '0;
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    case (state_r)
      S_CLR: begin
        n_we    = 1'b1;
        n_waddr = cnt_r[NW-1:0];
      end
      S_RDA: begin
        n_re    = 1'b1;
        n_raddr = NW'(a_r);
      end
      S_RDB: begin
        n_re    = 1'b1;
        n_raddr = NW'(b_r);
      end
      S_RSA: begin
        s_re    = 1'b1;
        s_raddr = ia;
      end
      S_RSB: begin
        s_re    = 1'b1;
        s_raddr = ib;
      end
      S_EXEC: begin
        if (out_free) begin
          if (ex_open) begin
            n_we    = 1'b1;
            n_waddr = NW'(a_r);
            n_wdata = {1'b1, ex_lab};
            s_we    = 1'b1;
            s_waddr = ex_lab;
            s_wdata = ex_sz;
          end else if (ex_case == icm_pkg::CASE_JOIN) begin
            n_we    = 1'b1;
            n_waddr = la ? NW'(b_r) : NW'(a_r);
            n_wdata = {1'b1, ex_lab};
            s_we    = 1'b1;
            s_waddr = ex_lab;
            s_wdata = ex_sz;
          end else if (ex_case == icm_pkg::CASE_MERGE) begin
            s_we    = 1'b1;
            s_waddr = ex_lab;
            s_wdata = ex_sz;
          end
        end
      end
      S_WB: begin
        n_we    = 1'b1;
        n_waddr = NW'(b_r);
        n_wdata = {1'b1, lab_r};
      end
      S_SCAN: begin
        if (cnt_r < CW'(NODES)) begin
          n_re    = 1'b1;
          n_raddr = cnt_r[NW-1:0];
        end
        if (scan_hit) begin
          n_we    = 1'b1;
          n_waddr = NW'(cnt_r - CW'(1));
          n_wdata = {1'b1, lab_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      node_mem[n_waddr] <= n_wdata;
    end
    if (n_re) begin
      n_rdata_r <= node_mem[n_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      size_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata_r <= size_mem[s_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      cnt_r        <= '0;
      free_r       <= '0;
      largest_r    <= '0;
      conn_r       <= '0;
      placed_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      case (state_r)
        S_CLR: begin
          if (cnt_r == CW'(NODES - 1)) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            a_r     <= in_tdata[IW-1:0];
            b_r     <= in_tdata[2*IW-1:IW];
            state_r <= S_RED;
          end
        end
        S_RED: begin
          // Node numbers at or above NODES fold back by repeated subtraction.
          if (32'(a_r) >= NODES) begin
            a_r <= a_r - IW'(NODES);
          end else if (32'(b_r) >= NODES) begin
            b_r <= b_r - IW'(NODES);
          end else begin
            state_r <= S_RDA;
          end
        end
        S_RDA: begin
          state_r <= S_RDB;
        end
        S_RDB: begin
          ent_a_r <= n_rdata_r;
          state_r <= S_RSA;
        end
        S_RSA: begin
          ent_b_r <= n_rdata_r;
          state_r <= S_RSB;
        end
        S_RSB: begin
          sa_r    <= s_rdata_r;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            out_tdata_r  <= out_tdata_nxt;
            out_tuser_r  <= ex_case;
            largest_r    <= largest_nxt;
            conn_r       <= conn_nxt;
            placed_r     <= placed_nxt;
            lab_r        <= ex_lab;
            lose_r       <= lose;
            if (ex_open) begin
              free_r  <= free_r + FW'(1);
              state_r <= S_WB;
            end else if (ex_case == icm_pkg::CASE_MERGE) begin
              cnt_r   <= '0;
              state_r <= S_SCAN;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_WB: begin
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          if (cnt_r == CW'(NODES)) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== rtl/icm_checker.sv =====
// Port-level assertions for the incremental cluster merge block, bound to its top level.
module icm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [icm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [icm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [icm_pkg::CASE_W-1:0]      out_tuser
);

  logic [icm_pkg::COUNT_W-1:0] nodes_f, largest_f, connected_f;

  assign nodes_f     = out_tdata[19:9];
  assign largest_f   = out_tdata[30:20];
  assign connected_f = out_tdata[41:31];

  // The node memory clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  // One item at a time: an accepted beat closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready in the cycle after a beat");

  // The largest cluster never holds more nodes than are connected.
  a_largest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> largest_f <= connected_f)
    else $error("largest cluster exceeds connected nodes");

  // A merged cluster holds at least four nodes and is accounted in the largest size.
  a_merge_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == icm_pkg::CASE_MERGE)
      |-> (nodes_f >= 11'd4) && (nodes_f <= largest_f))
    else $error("merged cluster size out of bounds");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

endmodule

bind incremental_cluster_merge icm_checker u_icm_checker (.*);
